FILE: design/assert_macros.svh
// Assertion macros shared by the grid RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property every clock edge outside reset.
`define LAG_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition implies another in the same cycle.
`define LAG_ASSERT_IMPL(lbl, clk, rst_n, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) else $error(msg);

// Check that a condition implies another in the next cycle.
`define LAG_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);

`endif

FILE: design/lag_pkg.sv
// Types and constants of the Life grid.
package lag_pkg;

  localparam int KIND_W = 3;
  localparam int ROW_W  = 6;
  localparam int COL_W  = 6;
  localparam int CFG_W  = 7;
  localparam int APB_AW = 3;
  localparam int APB_DW = 32;
  localparam int NBR_W  = 4;

  localparam logic [CFG_W-1:0] FIELD_RESET = 7'd64;

  localparam logic REG_ROWS = 1'b0;
  localparam logic REG_COLS = 1'b1;

  localparam logic [NBR_W-1:0] BIRTH_COUNT   = 4'd3;
  localparam logic [NBR_W-1:0] SURVIVE_COUNT = 4'd2;

  typedef enum logic [KIND_W-1:0] {
    KIND_SET_ALIVE = 3'd0,
    KIND_SET_DEAD  = 3'd1,
    KIND_CLEAR     = 3'd2,
    KIND_STEP      = 3'd3,
    KIND_COMMIT    = 3'd4,
    KIND_READ      = 3'd5
  } kind_e;

  typedef struct packed {
    logic rotate;
    logic step_wr;
    logic set_wr;
    logic set_val;
    logic clear;
    logic commit;
    logic top_ok;
    logic bot_ok;
    logic row_in;
  } cell_ctrl_t;

endpackage

FILE: design/lag_in_if.sv
// Input word channel of the Life grid.
interface lag_in_if;
  logic                       valid;
  logic                       ready;
  logic [lag_pkg::KIND_W-1:0] kind;
  logic [lag_pkg::ROW_W-1:0]  cell_row;
  logic [lag_pkg::COL_W-1:0]  cell_column;

  modport source (output valid, kind, cell_row, cell_column, input ready);
  modport sink (input valid, kind, cell_row, cell_column, output ready);
endinterface

FILE: design/lag_out_if.sv
// Result word channel of the Life grid.
interface lag_out_if;
  logic valid;
  logic ready;
  logic cell_value;
  logic accepted;

  modport source (output valid, cell_value, accepted, input ready);
  modport sink (input valid, cell_value, accepted, output ready);
endinterface

FILE: design/lag_column_cell.sv
// One column of both planes, rotating its rows and applying the B3/S23 rule.
module lag_column_cell #(
  parameter int ROWS = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  lag_pkg::cell_ctrl_t ctrl_i,
  input  logic                sel_i,
  input  logic                col_ok_i,
  input  logic [2:0]          left_i,
  input  logic [2:0]          right_i,
  output logic [2:0]          nbr_o,
  output logic                cur_o
);

  localparam int NW = lag_pkg::NBR_W;

  logic [ROWS-1:0] cur_q, cur_d;
  logic [ROWS-1:0] nxt_q, nxt_d;
  logic            above;
  logic            below;
  logic [NW-1:0]   count;
  logic            live;

  assign above = cur_q[ROWS-1] & ctrl_i.top_ok;
  assign below = cur_q[1] & ctrl_i.bot_ok;
  assign nbr_o = col_ok_i ? {above, cur_q[0], below} : 3'b000;
  assign cur_o = cur_q[0];

  assign count = NW'(above) + NW'(below)
               + NW'(left_i[2]) + NW'(left_i[1]) + NW'(left_i[0])
               + NW'(right_i[2]) + NW'(right_i[1]) + NW'(right_i[0]);

  assign live = (count == lag_pkg::BIRTH_COUNT) ||
                (cur_q[0] && (count == lag_pkg::SURVIVE_COUNT));

  always_comb begin
    cur_d = cur_q;
    nxt_d = nxt_q;
    if (ctrl_i.clear) begin
      nxt_d = '0;
    end else if (ctrl_i.commit) begin
      cur_d = nxt_q;
    end else if (ctrl_i.rotate) begin
      cur_d = {cur_q[0], cur_q[ROWS-1:1]};
      nxt_d = {(ctrl_i.step_wr && ctrl_i.row_in && col_ok_i) ? live : nxt_q[0],
               nxt_q[ROWS-1:1]};
    end else if (ctrl_i.set_wr && sel_i) begin
      nxt_d[0] = ctrl_i.set_val;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q <= '0;
      nxt_q <= '0;
    end else begin
      cur_q <= cur_d;
      nxt_q <= nxt_d;
    end
  end

endmodule

FILE: design/life_automaton_grid.sv
// Top level of the Life grid: control, field registers and the chain of column cells.
//
//  channel | dir | word fields                   | handshake
//  in_i    | in  | kind, cell_row, cell_column   | valid / ready
//  out_o   | out | cell_value, accepted          | valid / ready
//  apb     | in  | field_rows @0, field_columns @4 | psel / penable / pwrite
//
// One item at a time; rows rotate through the cells, one row per cycle.
// Clear, commit, bad kinds and rejected set/read pass straight through the done state to the result register.
// Set and read: rows rotate until the target row reaches tap 0, then the result is written.
// Step: one sweep of all rows with every column in parallel.
// Reset clears both planes at once; a stalled result holds and the next word is taken.
`include "assert_macros.svh"

module life_automaton_grid #(
  parameter int MAX_ROWS    = 64,
  parameter int MAX_COLUMNS = 64
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  lag_in_if.sink                       in_i,
  lag_out_if.source                    out_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [lag_pkg::APB_AW-1:0]   paddr,
  input  logic [lag_pkg::APB_DW-1:0]   pwdata,
  output logic [lag_pkg::APB_DW-1:0]   prdata,
  output logic                         pready
);

  localparam int CW  = lag_pkg::CFG_W;
  localparam int RW  = $clog2(MAX_ROWS);
  localparam int RCW = ($clog2(MAX_ROWS + 1) > CW) ? $clog2(MAX_ROWS + 1) : CW;
  localparam int CCW = ($clog2(MAX_COLUMNS + 1) > CW) ? $clog2(MAX_COLUMNS + 1) : CW;
  localparam logic [RW-1:0] LAST_ROW = RW'(MAX_ROWS - 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SEEK,
    S_STEP,
    S_DONE
  } state_e;

  logic [CW-1:0] rows_q, cols_q;
  logic          cfg_wr;

  assign cfg_wr = psel && penable && pwrite;
  assign pready = 1'b1;
  assign prdata = {{(lag_pkg::APB_DW - CW){1'b0}},
                   (paddr[lag_pkg::APB_AW-1] == lag_pkg::REG_COLS) ? cols_q : rows_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q <= lag_pkg::FIELD_RESET;
      cols_q <= lag_pkg::FIELD_RESET;
    end else if (cfg_wr) begin
      if (paddr[lag_pkg::APB_AW-1] == lag_pkg::REG_ROWS) begin
        rows_q <= pwdata[CW-1:0];
      end else begin
        cols_q <= pwdata[CW-1:0];
      end
    end
  end

  logic [RCW-1:0] used_rows;
  logic [CCW-1:0] used_cols;

  assign used_rows = (RCW'(rows_q) > RCW'(MAX_ROWS)) ? RCW'(MAX_ROWS) : RCW'(rows_q);
  assign used_cols = (CCW'(cols_q) > CCW'(MAX_COLUMNS)) ? CCW'(MAX_COLUMNS) : CCW'(cols_q);

  state_e                     state_q, state_d;
  lag_pkg::kind_e             kind_q, kind_d;
  logic [lag_pkg::ROW_W-1:0]  row_q, row_d;
  logic [lag_pkg::COL_W-1:0]  col_q, col_d;
  logic [RW-1:0]              offset_q, offset_d, offset_inc;
  logic [RW-1:0]              cnt_q, cnt_d;
  logic                       res_val_q, res_val_d;
  logic                       res_ok_q, res_ok_d;
  logic                       out_valid_q, out_valid_d;
  logic                       out_val_q, out_val_d;
  logic                       out_ok_q, out_ok_d;
  lag_pkg::cell_ctrl_t        ctrl;
  logic                       inside_in;
  logic                       hit;
  logic                       read_bit;

  logic [MAX_COLUMNS-1:0]     sel;
  logic [MAX_COLUMNS-1:0]     col_ok;
  logic [MAX_COLUMNS-1:0]     cur0;
  logic [2:0]                 nbr   [MAX_COLUMNS];
  logic [2:0]                 left  [MAX_COLUMNS];
  logic [2:0]                 right [MAX_COLUMNS];

  assign inside_in = (RCW'(in_i.cell_row) < used_rows) &&
                     (CCW'(in_i.cell_column) < used_cols);
  assign hit        = RCW'(offset_q) == RCW'(row_q);
  assign offset_inc = (offset_q == LAST_ROW) ? '0 : offset_q + RW'(1);
  assign read_bit   = |(cur0 & sel);

  assign in_i.ready       = state_q == S_IDLE;
  assign out_o.valid      = out_valid_q;
  assign out_o.cell_value = out_val_q;
  assign out_o.accepted   = out_ok_q;

  always_comb begin
    state_d        = state_q;
    kind_d         = kind_q;
    row_d          = row_q;
    col_d          = col_q;
    offset_d       = offset_q;
    cnt_d          = cnt_q;
    res_val_d      = res_val_q;
    res_ok_d       = res_ok_q;
    out_valid_d    = out_valid_q;
    out_val_d      = out_val_q;
    out_ok_d       = out_ok_q;
    ctrl           = '0;
    ctrl.top_ok    = offset_q != '0;
    ctrl.bot_ok    = (RCW'(offset_q) + RCW'(1)) < used_rows;
    ctrl.row_in    = RCW'(offset_q) < used_rows;

    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_i.valid) begin
          kind_d    = lag_pkg::kind_e'(in_i.kind);
          row_d     = in_i.cell_row;
          col_d     = in_i.cell_column;
          res_val_d = 1'b0;
          res_ok_d  = 1'b0;
          state_d   = S_DONE;
          unique case (lag_pkg::kind_e'(in_i.kind))
            lag_pkg::KIND_SET_ALIVE,
            lag_pkg::KIND_SET_DEAD,
            lag_pkg::KIND_READ: begin
              if (inside_in) begin
                state_d = S_SEEK;
              end
            end
            lag_pkg::KIND_CLEAR: begin
              ctrl.clear = 1'b1;
              res_ok_d   = 1'b1;
            end
            lag_pkg::KIND_STEP: begin
              state_d = S_STEP;
            end
            lag_pkg::KIND_COMMIT: begin
              ctrl.commit = 1'b1;
              res_ok_d    = 1'b1;
            end
            default: begin
            end
          endcase
        end
      end
      S_SEEK: begin
        if (hit) begin
          state_d  = S_DONE;
          res_ok_d = 1'b1;
          if (kind_q == lag_pkg::KIND_READ) begin
            res_val_d = read_bit;
          end else begin
            ctrl.set_wr  = 1'b1;
            ctrl.set_val = kind_q == lag_pkg::KIND_SET_ALIVE;
          end
        end else begin
          ctrl.rotate = 1'b1;
          offset_d    = offset_inc;
        end
      end
      S_STEP: begin
        ctrl.rotate  = 1'b1;
        ctrl.step_wr = 1'b1;
        offset_d     = offset_inc;
        if (cnt_q == LAST_ROW) begin
          cnt_d    = '0;
          res_ok_d = 1'b1;
          state_d  = S_DONE;
        end else begin
          cnt_d = cnt_q + RW'(1);
        end
      end
      S_DONE: begin
        if (!out_valid_q || out_o.ready) begin
          out_valid_d = 1'b1;
          out_val_d   = res_val_q;
          out_ok_d    = res_ok_q;
          state_d     = S_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      kind_q      <= lag_pkg::KIND_SET_ALIVE;
      row_q       <= '0;
      col_q       <= '0;
      offset_q    <= '0;
      cnt_q       <= '0;
      res_val_q   <= 1'b0;
      res_ok_q    <= 1'b0;
      out_valid_q <= 1'b0;
      out_val_q   <= 1'b0;
      out_ok_q    <= 1'b0;
    end else begin
      state_q     <= state_d;
      kind_q      <= kind_d;
      row_q       <= row_d;
      col_q       <= col_d;
      offset_q    <= offset_d;
      cnt_q       <= cnt_d;
      res_val_q   <= res_val_d;
      res_ok_q    <= res_ok_d;
      out_valid_q <= out_valid_d;
      out_val_q   <= out_val_d;
      out_ok_q    <= out_ok_d;
    end
  end

  for (genvar c = 0; c < MAX_COLUMNS; c++) begin : g_col
    assign sel[c]    = CCW'(col_q) == CCW'(c);
    assign col_ok[c] = CCW'(c) < used_cols;

    if (c == 0) begin : g_left_edge
      assign left[c] = 3'b000;
    end else begin : g_left
      assign left[c] = nbr[c-1];
    end

    if (c == MAX_COLUMNS - 1) begin : g_right_edge
      assign right[c] = 3'b000;
    end else begin : g_right
      assign right[c] = nbr[c+1];
    end

    lag_column_cell #(
      .ROWS (MAX_ROWS)
    ) u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .ctrl_i   (ctrl),
      .sel_i    (sel[c]),
      .col_ok_i (col_ok[c]),
      .left_i   (left[c]),
      .right_i  (right[c]),
      .nbr_o    (nbr[c]),
      .cur_o    (cur0[c])
    );
  end

  `LAG_ASSERT_IMPL(a_cnt_outside_step, clk_i, rst_ni, state_q != S_STEP, cnt_q == '0, "step count left nonzero")
  `LAG_ASSERT_NEXT(a_accept_starts_work, clk_i, rst_ni, in_i.valid && in_i.ready, state_q != S_IDLE, "accepted word did not start work")
  `LAG_ASSERT_IMPL(a_seek_in_field, clk_i, rst_ni, state_q == S_SEEK, RCW'(row_q) < used_rows, "row search outside the field")

endmodule
